### rtl/core/vad_pkg.sv
// ----------------------------------------------------------------------------
// vad_pkg: shared types and constants for the vector angle unit
// Fixed-point formats, CORDIC arctangent table and the stage payload struct.
// ----------------------------------------------------------------------------
package vad_pkg;

  // Coordinate width and CORDIC iteration count
  localparam int COORD_BITS   = 16;
  localparam int ANGLE_STAGES = 24;
  localparam int TABLE_LEN    = 32;
  localparam int NSTAGE       = (ANGLE_STAGES < TABLE_LEN) ? ANGLE_STAGES : TABLE_LEN;

  // Datapath widths
  localparam int DATA_W     = 64;
  localparam int GUARD      = 60 - COORD_BITS;
  localparam int Z_W        = 32;
  localparam int ANGLE_FRAC = 24;
  localparam int FULL_W     = 34;
  localparam int DEGI_W     = FULL_W - ANGLE_FRAC;
  localparam int DEG_W      = 9;

  // Angle constants, degrees with ANGLE_FRAC fractional bits
  localparam logic [Z_W-1:0]    DEG45_Z   = Z_W'(64'd45 << ANGLE_FRAC);
  localparam logic [FULL_W-1:0] DEG90_F   = FULL_W'(64'd90 << ANGLE_FRAC);
  localparam logic [FULL_W-1:0] DEG180_F  = FULL_W'(64'd180 << ANGLE_FRAC);
  localparam logic [FULL_W-1:0] DEG360_F  = FULL_W'(64'd360 << ANGLE_FRAC);
  localparam logic [DEGI_W-1:0] DEG_WRAP  = DEGI_W'(360);

  // atan(2^-i) in degrees, rounded to the nearest unit
  localparam logic [Z_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
    32'd30029717,  32'd15018523,  32'd7509720,   32'd3754917,   32'd1877466,
    32'd938734,    32'd469367,    32'd234684,    32'd117342,    32'd58671,
    32'd29335,     32'd14668,     32'd7334,      32'd3667,      32'd1833,
    32'd917,       32'd458,       32'd229,       32'd115,       32'd57,
    32'd29,        32'd14,        32'd7,         32'd4,         32'd2,
    32'd1,         32'd0
  };

  // How the octant angle is obtained
  typedef enum logic [1:0] {
    KIND_AXIS   = 2'd0,
    KIND_DIAG   = 2'd1,
    KIND_CORDIC = 2'd2
  } kind_e;

  // Payload carried down the pipeline
  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic        [Z_W-1:0]    z;
    logic                     dx_neg;
    logic                     dy_neg;
    logic                     swapped;
    kind_e                    kind;
  } stage_t;

endpackage

### rtl/core/vector_angle_degrees_unit.sv
// ----------------------------------------------------------------------------
// vector_angle_degrees_unit: heading from a start point to an end point
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one transaction per point
//   pair: start_x_i, start_y_i, end_x_i, end_y_i, unsigned coordinates.
//   Output channel (out_valid_o / out_ready_i) returns heading_deg_o, the
//   direction counter-clockwise from +x in whole degrees, 0 to 359.
//   Equal points give 0; axis and diagonal directions are exact.
// Pipeline: 27 register stages from input accept to output valid: one fold
//   stage, 24 CORDIC micro-rotation stages, one unfold stage and the output
//   register; the fold stage loads at the accepting edge.
// Throughput: one transaction per cycle while the receiver keeps up; the CORDIC is fully pipelined.
// Reset: all valid bits clear, the pipeline is empty and in_ready_o is high.
// Stall: a stalled receiver holds its result in the output register, the
//   next result lands in a skid stage, and only then does the whole
//   pipeline freeze and in_ready_o drop. No transaction is lost or repeated.
// ----------------------------------------------------------------------------
module vector_angle_degrees_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [vad_pkg::COORD_BITS-1:0] start_x_i,
  input  logic [vad_pkg::COORD_BITS-1:0] start_y_i,
  input  logic [vad_pkg::COORD_BITS-1:0] end_x_i,
  input  logic [vad_pkg::COORD_BITS-1:0] end_y_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [vad_pkg::DEG_W-1:0]      heading_deg_o
);
  import vad_pkg::*;

  logic             en;
  logic             front_v, cordic_v, back_v;
  stage_t           front_s, cordic_s;
  logic [DEG_W-1:0] back_deg;

  assign in_ready_o = en;

  // Fold into the first octant
  vad_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .valid_o   (front_v),
    .stage_o   (front_s)
  );

  // CORDIC vectoring pipeline
  vad_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_v),
    .stage_i (front_s),
    .valid_o (cordic_v),
    .stage_o (cordic_s)
  );

  // Unfold to whole degrees
  vad_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cordic_v),
    .stage_i (cordic_s),
    .valid_o (back_v),
    .deg_o   (back_deg)
  );

  // Output register and skid stage
  vad_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (back_v),
    .deg_i       (back_deg),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .deg_o       (heading_deg_o)
  );

endmodule

### rtl/core/vad_front.sv
// ----------------------------------------------------------------------------
// vad_front: difference, magnitude and octant fold
// Forms dx/dy, folds the vector into the first octant and loads CORDIC x/y.
// ----------------------------------------------------------------------------
module vad_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [vad_pkg::COORD_BITS-1:0] start_x_i,
  input  logic [vad_pkg::COORD_BITS-1:0] start_y_i,
  input  logic [vad_pkg::COORD_BITS-1:0] end_x_i,
  input  logic [vad_pkg::COORD_BITS-1:0] end_y_i,
  output logic                          valid_o,
  output vad_pkg::stage_t               stage_o
);
  import vad_pkg::*;

  logic signed [COORD_BITS:0] dx, dy;
  logic        [COORD_BITS:0] abs_x, abs_y;
  logic [COORD_BITS-1:0]      mag_x, mag_y, mag_hi, mag_lo;
  logic                       swap;
  stage_t                     stage_d, stage_q;
  logic                       valid_q;

  // Signed differences and their magnitudes
  always_comb begin
    dx    = $signed({1'b0, end_x_i}) - $signed({1'b0, start_x_i});
    dy    = $signed({1'b0, end_y_i}) - $signed({1'b0, start_y_i});
    abs_x = dx[COORD_BITS] ? -dx : dx;
    abs_y = dy[COORD_BITS] ? -dy : dy;
    mag_x = abs_x[COORD_BITS-1:0];
    mag_y = abs_y[COORD_BITS-1:0];
    swap  = mag_y > mag_x;
    mag_hi = swap ? mag_y : mag_x;
    mag_lo = swap ? mag_x : mag_y;
  end

  // Fold into the first octant and classify
  always_comb begin
    stage_d.x       = DATA_W'(mag_hi) << GUARD;
    stage_d.y       = DATA_W'(mag_lo) << GUARD;
    stage_d.z       = '0;
    stage_d.dx_neg  = dx[COORD_BITS];
    stage_d.dy_neg  = dy[COORD_BITS];
    stage_d.swapped = swap;
    if (mag_lo == '0) begin
      stage_d.kind = KIND_AXIS;
    end else if (mag_lo == mag_hi) begin
      stage_d.kind = KIND_DIAG;
    end else begin
      stage_d.kind = KIND_CORDIC;
    end
  end

  // Advance valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

### rtl/core/vad_cordic.sv
// ----------------------------------------------------------------------------
// vad_cordic: pipelined CORDIC vectoring stages
// One registered micro-rotation per stage, driving y toward zero.
// ----------------------------------------------------------------------------
module vad_cordic (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  vad_pkg::stage_t stage_i,
  output logic            valid_o,
  output vad_pkg::stage_t stage_o
);
  import vad_pkg::*;

  logic   [NSTAGE-1:0] valid_q;
  stage_t              stage_q [NSTAGE];

  for (genvar i = 0; i < NSTAGE; i++) begin : g_stage
    stage_t                   cur;
    stage_t                   stage_d;
    logic                     cur_v;
    logic signed [DATA_W-1:0] xs, ys;

    // Select stage input
    if (i == 0) begin : g_first
      assign cur   = stage_i;
      assign cur_v = valid_i;
    end else begin : g_next
      assign cur   = stage_q[i-1];
      assign cur_v = valid_q[i-1];
    end

    // Rotate by atan(2^-i) toward the x axis
    always_comb begin
      xs      = $signed(cur.x) >>> i;
      ys      = $signed(cur.y) >>> i;
      stage_d = cur;
      if ($signed(cur.y) > 0) begin
        stage_d.x = cur.x + ys;
        stage_d.y = cur.y - xs;
        stage_d.z = cur.z + ATAN_TAB[i];
      end else begin
        stage_d.x = cur.x - ys;
        stage_d.y = cur.y + xs;
        stage_d.z = cur.z - ATAN_TAB[i];
      end
    end

    // Advance valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (en_i) begin
        valid_q[i] <= cur_v;
      end
    end

    // Advance payload
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[i] <= stage_d;
      end
    end
  end

  assign valid_o = valid_q[NSTAGE-1];
  assign stage_o = stage_q[NSTAGE-1];

endmodule

### rtl/core/vad_back.sv
// ----------------------------------------------------------------------------
// vad_back: octant unfold and truncation to whole degrees
// Picks or clamps the octant angle, maps it to the full circle and wraps 360 to 0.
// ----------------------------------------------------------------------------
module vad_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  vad_pkg::stage_t           stage_i,
  output logic                      valid_o,
  output logic [vad_pkg::DEG_W-1:0] deg_o
);
  import vad_pkg::*;

  logic [Z_W-1:0]    z_oct;
  logic [FULL_W-1:0] a_quad, full;
  logic [DEGI_W-1:0] deg_int;
  logic [DEG_W-1:0]  deg_d, deg_q;
  logic              valid_q;

  // Pick and clamp the octant angle
  always_comb begin
    case (stage_i.kind)
      KIND_AXIS: z_oct = '0;
      KIND_DIAG: z_oct = DEG45_Z;
      default: begin
        if ($signed(stage_i.z) < 0) begin
          z_oct = '0;
        end else if ($signed(stage_i.z) > $signed(DEG45_Z)) begin
          z_oct = DEG45_Z;
        end else begin
          z_oct = stage_i.z;
        end
      end
    endcase
  end

  // Unfold to the full circle and truncate
  always_comb begin
    a_quad = stage_i.swapped ? DEG90_F - FULL_W'(z_oct) : FULL_W'(z_oct);
    if (!stage_i.dy_neg) begin
      full = stage_i.dx_neg ? DEG180_F - a_quad : a_quad;
    end else begin
      full = stage_i.dx_neg ? DEG180_F + a_quad : DEG360_F - a_quad;
    end
    deg_int = full[FULL_W-1:ANGLE_FRAC];
    deg_d   = (deg_int >= DEG_WRAP) ? '0 : deg_int[DEG_W-1:0];
  end

  // Advance valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Advance result
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      deg_q <= deg_d;
    end
  end

  assign valid_o = valid_q;
  assign deg_o   = deg_q;

`ifndef ASSERT_OFF
  // Axis directions come out exact
  a_axis_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && valid_i && stage_i.kind == KIND_AXIS) |=>
      (deg_q == DEG_W'(0) || deg_q == DEG_W'(90) ||
       deg_q == DEG_W'(180) || deg_q == DEG_W'(270)))
    else $error("axis direction not a multiple of 90");

  // Diagonal directions come out exact
  a_diag_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && valid_i && stage_i.kind == KIND_DIAG) |=>
      (deg_q == DEG_W'(45) || deg_q == DEG_W'(135) ||
       deg_q == DEG_W'(225) || deg_q == DEG_W'(315)))
    else $error("diagonal direction not an odd multiple of 45");
`endif

endmodule

### rtl/core/vad_out_buf.sv
// ----------------------------------------------------------------------------
// vad_out_buf: output register with skid stage
// Holds results for a stalled receiver and stalls the pipeline when full.
// ----------------------------------------------------------------------------
module vad_out_buf (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [vad_pkg::DEG_W-1:0] deg_i,
  output logic                      en_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [vad_pkg::DEG_W-1:0] deg_o
);
  import vad_pkg::*;

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  logic [DEG_W-1:0] out_q, out_d, skid_q, skid_d;

  // Pipeline moves whenever the skid stage is empty
  assign en_o = !skid_valid_q;

  // Next state of output and skid registers
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_ready_i) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_d = valid_i;
      out_d       = deg_i;
    end else if (valid_i) begin
      skid_valid_d = 1'b1;
      skid_d       = deg_i;
    end
  end

  // Hold valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Hold payloads
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign deg_o       = out_q;

`ifndef ASSERT_OFF
  // Skid only holds a transaction behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage full with output register empty");

  // Skid fills only when the output was stalled
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !out_ready_i))
    else $error("skid stage filled without a stall");
`endif

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for vector_angle_degrees_unit
// Drives point pairs through the valid/ready input channel and checks every
// heading against a CORDIC heading predictor built into the bench. A directed
// set covers the axes, the diagonals, equal points and the near-360 wrap. A
// random set follows with random idling on both sides and two long receiver
// hold-offs that fill the pipeline and stall the input.
// ----------------------------------------------------------------------------
module tb_top;
  import vad_pkg::*;

  localparam int     CLK_HALF       = 4;
  localparam int     RANDOM_PAIRS   = 650;
  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     DRAIN_CYCLES   = 60;
  localparam int     LONG_HOLD      = 300;
  localparam int     MAX_PRINTS     = 100;
  localparam int     Q_FRAC         = 24;
  localparam int     CORDIC_ITERS   = 24;
  localparam int     PRESHIFT       = 60 - COORD_BITS;
  localparam longint DEG_UNIT       = 64'sd1 << Q_FRAC;

  // atan(2^-i) in degrees, Q24
  localparam longint ATAN_DEG_Q24 [32] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
    117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
    115, 57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [DEG_W-1:0]      heading_t;

  typedef struct {
    coord_t      sx;
    coord_t      sy;
    coord_t      ex;
    coord_t      ey;
    int unsigned gap;
  } point_pair_t;

  typedef struct {
    coord_t   sx;
    coord_t   sy;
    coord_t   ex;
    coord_t   ey;
    heading_t heading;
  } heading_exp_t;

  logic     clk_i         = 1'b0;
  logic     rst_ni        = 1'b0;
  logic     in_valid_i    = 1'b0;
  logic     in_ready_o;
  coord_t   start_x_i     = '0;
  coord_t   start_y_i     = '0;
  coord_t   end_x_i       = '0;
  coord_t   end_y_i       = '0;
  logic     out_valid_o;
  logic     out_ready_i   = 1'b0;
  heading_t heading_deg_o;

  point_pair_t  pair_q [$];
  heading_exp_t heading_q [$];
  heading_exp_t oldest;
  point_pair_t  cur_pair;

  logic        in_fire  = 1'b0;
  logic        out_fire = 1'b0;
  int unsigned pairs_added  = 0;
  int unsigned results_seen = 0;
  int unsigned error_count  = 0;
  int unsigned idle_cycles  = 0;
  int unsigned tx_wait      = 0;
  bit          tx_wait_set  = 1'b0;
  int unsigned rx_wait      = 0;
  int unsigned rx_hold      = 0;

  vector_angle_degrees_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .heading_deg_o (heading_deg_o)
  );

  // Predict the heading of one point pair
  function automatic heading_t predict_heading(input coord_t sx, input coord_t sy,
                                               input coord_t ex, input coord_t ey);
    longint dx, dy, ax, ay, t, x, y, xs, ys, z, a, full, deg;
    bit     swapped;
    dx = longint'(ex) - longint'(sx);
    dy = longint'(ey) - longint'(sy);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    swapped = 1'b0;
    // fold into the first octant
    if (ay > ax) begin
      t = ax;
      ax = ay;
      ay = t;
      swapped = 1'b1;
    end
    if (ay == 0) begin
      z = 0;
    end else if (ay == ax) begin
      z = 45 * DEG_UNIT;
    end else begin
      x = ax <<< PRESHIFT;
      y = ay <<< PRESHIFT;
      z = 0;
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_DEG_Q24[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_DEG_Q24[i];
        end
      end
      if (z < 0) z = 0;
      if (z > 45 * DEG_UNIT) z = 45 * DEG_UNIT;
    end
    // unfold into the full circle
    a = swapped ? 90 * DEG_UNIT - z : z;
    if (dy >= 0) begin
      full = (dx >= 0) ? a : 180 * DEG_UNIT - a;
    end else begin
      full = (dx < 0) ? 180 * DEG_UNIT + a : 360 * DEG_UNIT - a;
    end
    deg = full >>> Q_FRAC;
    if (deg >= 360) deg = 0;
    return heading_t'(deg);
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Queue one point pair; every third block of 40 pairs runs without gaps
  task automatic add_pair(input coord_t sx, input coord_t sy, input coord_t ex,
                          input coord_t ey);
    point_pair_t p;
    p.sx  = sx;
    p.sy  = sy;
    p.ex  = ex;
    p.ey  = ey;
    p.gap = ((pairs_added / 40) % 3 == 1) ? 0 : $urandom_range(0, 9);
    pair_q.push_back(p);
    pairs_added++;
  endtask

  // Clock
  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Sender: offer queued pairs, hold each until the transaction completes
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (pair_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else begin
        if (!tx_wait_set) begin
          tx_wait = pair_q[0].gap;
          tx_wait_set = 1'b1;
        end
        if (tx_wait > 0) begin
          in_valid_i <= 1'b0;
          tx_wait--;
        end else begin
          cur_pair = pair_q.pop_front();
          tx_wait_set = 1'b0;
          start_x_i  <= cur_pair.sx;
          start_y_i  <= cur_pair.sy;
          end_x_i    <= cur_pair.ex;
          end_y_i    <= cur_pair.ey;
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // Receiver: random stall after each result, plus long hold-offs
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_fire) begin
        rx_wait = ((results_seen / 50) % 3 == 2) ? 0 : $urandom_range(0, 9);
        if (results_seen == 200 || results_seen == 450) rx_hold = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        out_ready_i <= 1'b0;
        rx_hold--;
      end else if (rx_wait > 0) begin
        out_ready_i <= 1'b0;
        rx_wait--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Monitor: check results in order, then record new expectations
  always @(posedge clk_i) begin
    in_fire  <= rst_ni && in_valid_i && in_ready_o;
    out_fire <= rst_ni && out_valid_o && out_ready_i;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (heading_q.size() == 0) begin
          report_error($sformatf("unexpected heading %0d", heading_deg_o));
        end else begin
          oldest = heading_q.pop_front();
          if (heading_deg_o !== oldest.heading)
            report_error($sformatf("heading (%0d,%0d)->(%0d,%0d): got %0d, exp %0d",
                                   oldest.sx, oldest.sy, oldest.ex, oldest.ey,
                                   heading_deg_o, oldest.heading));
        end
      end
      if (in_valid_i && in_ready_o) begin
        heading_q.push_back('{sx: start_x_i, sy: start_y_i, ex: end_x_i, ey: end_y_i,
                              heading: predict_heading(start_x_i, start_y_i,
                                                       end_x_i, end_y_i)});
      end
    end
  end

  // Watchdog: abort when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    int          mode;
    int          dx, dy, mag;
    coord_t      sx, sy;
    // directed: equal points
    add_pair(16'd0, 16'd0, 16'd0, 16'd0);
    add_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // directed: axes at full span
    add_pair(16'd0, 16'd0, 16'hFFFF, 16'd0);
    add_pair(16'hFFFF, 16'd0, 16'd0, 16'd0);
    add_pair(16'd0, 16'd0, 16'd0, 16'hFFFF);
    add_pair(16'd0, 16'hFFFF, 16'd0, 16'd0);
    // directed: diagonals at full span and unit size
    add_pair(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    add_pair(16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
    add_pair(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    add_pair(16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
    add_pair(16'd100, 16'd100, 16'd101, 16'd101);
    add_pair(16'd100, 16'd100, 16'd99, 16'd101);
    // directed: tiny angles around +x, including the wrap just below 360
    add_pair(16'd0, 16'd1, 16'hFFFF, 16'd0);
    add_pair(16'd0, 16'd0, 16'hFFFF, 16'd1);
    // directed: unit steps along the axes
    add_pair(16'd5, 16'd5, 16'd6, 16'd5);
    add_pair(16'd5, 16'd5, 16'd5, 16'd4);
    // directed: just off the diagonals and the vertical axis
    add_pair(16'd0, 16'd0, 16'hFFFF, 16'hFFFE);
    add_pair(16'd0, 16'd0, 16'hFFFE, 16'hFFFF);
    add_pair(16'd0, 16'd0, 16'd1, 16'hFFFF);
    add_pair(16'hFFFF, 16'd0, 16'd0, 16'hFFFE);
    add_pair(16'd0, 16'hFFFF, 16'hFFFF, 16'd1);
    add_pair(16'd1, 16'hFFFF, 16'd0, 16'd0);
    add_pair(16'd0, 16'hFFFF, 16'd1, 16'd0);
    add_pair(16'd32768, 16'd32768, 16'd0, 16'hFFFF);
    add_pair(16'd12345, 16'd54321, 16'hFFFF, 16'd0);

    // random pairs
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      mode = $urandom_range(0, 9);
      sx = coord_t'($urandom);
      sy = coord_t'($urandom);
      case (mode)
        0, 1, 2, 3: begin
          add_pair(sx, sy, coord_t'($urandom), coord_t'($urandom));
        end
        4, 5: begin
          dx = $urandom_range(0, 80) - 40;
          dy = $urandom_range(0, 80) - 40;
          add_pair(sx, sy, coord_t'(sx + dx), coord_t'(sy + dy));
        end
        6: begin
          // near an axis
          mag = $urandom_range(1, 65535);
          dx = $urandom_range(0, 4) - 2;
          if ($urandom_range(0, 1)) begin
            add_pair(16'd0 + coord_t'(dx < 0 ? 2 : 0), sy,
                     coord_t'((dx < 0 ? 2 : 0) + dx), coord_t'(sy + mag));
          end else begin
            add_pair(sx, 16'd2, coord_t'(sx - mag), coord_t'(2 + dx));
          end
        end
        7: begin
          // near a diagonal, full-range magnitude
          mag = $urandom_range(1, 32767);
          dy = mag + $urandom_range(0, 4) - 2;
          dx = $urandom_range(0, 1) ? mag : -mag;
          if ($urandom_range(0, 1)) dy = -dy;
          add_pair(16'd32768, 16'd32768, coord_t'(32768 + dx), coord_t'(32768 + dy));
        end
        8: begin
          // exact axis or diagonal, random size and signs
          mag = $urandom_range(1, 32767);
          dx = $urandom_range(0, 1) ? mag : -mag;
          dy = $urandom_range(0, 1) ? mag : -mag;
          case ($urandom_range(0, 2))
            0: dx = 0;
            1: dy = 0;
            default: ;
          endcase
          add_pair(16'd32768, 16'd32768, coord_t'(32768 + dx), coord_t'(32768 + dy));
        end
        default: begin
          // equal points or corner-to-corner
          if ($urandom_range(0, 1)) begin
            add_pair(sx, sy, sx, sy);
          end else begin
            add_pair($urandom_range(0, 1) ? 16'hFFFF : 16'd0,
                     $urandom_range(0, 1) ? 16'hFFFF : 16'd0,
                     $urandom_range(0, 1) ? 16'hFFFF : 16'd0,
                     $urandom_range(0, 1) ? 16'hFFFF : 16'd0);
          end
        end
      endcase
    end

    // hold reset, then release it away from the rising edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // drain: all pairs sent, all headings back, then let the pipeline settle
    while (pair_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (heading_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/vad_pkg.sv
rtl/core/vad_front.sv
rtl/core/vad_cordic.sv
rtl/core/vad_back.sv
rtl/core/vad_out_buf.sv
rtl/core/vector_angle_degrees_unit.sv
dv/tb_top.sv
